// File: rtl/patbl_pkg.sv
// Package for the per-address token bucket limiter: sizes, constants, FSM state type.
// Used by patbl_div and the top level.
`timescale 1ns / 1ps
package patbl_pkg;
   localparam int TableSlots  = 1024;
   localparam int SlotIdxW    = 10;
   localparam int ProbeWindow = 32;
   localparam int ProbeW      = 6;
   localparam int TokenScale  = 1000;
   localparam logic [7:0]  TagIpv4   = 8'd2;
   localparam logic [7:0]  TagIpv6   = 8'd10;
   localparam logic [63:0] HashBasis = 64'd14695981039346656037;
   localparam logic [63:0] HashMult  = 64'd1099511628211;

   localparam logic [2:0] RegRefill   = 3'd0;
   localparam logic [2:0] RegPeriod   = 3'd1;
   localparam logic [2:0] RegCapacity = 3'd2;
   localparam logic [2:0] RegSlots    = 3'd3;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_MUL,
      ST_HASH_ACC,
      ST_MOD_START,
      ST_MOD_WAIT,
      ST_PROBE_RD,
      ST_PROBE_WAIT,
      ST_PROBE_CHK,
      ST_HIT_RD,
      ST_HIT_WAIT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_UPDATE,
      ST_OUT
   } state_type;

   // Request to the shared divider: start pulse and operands
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;
endpackage

// File: rtl/patbl_div.sv
// Restoring radix-2 divider: 64-bit dividend by 64-bit divisor, one bit per cycle.
// Depends on patbl_pkg.
`timescale 1ns / 1ps
module patbl_div
   import patbl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [63:0] quotient,
   output logic [63:0] remainder
);
   logic [63:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;
   logic [64:0] shifted;

   // one shift-subtract step per cycle
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      shifted = {r_ff, q_ff[63]};
      trial = shifted - {1'b0, d_ff};
      if (req.start) begin
         q_in = req.dividend;
         r_in = '0;
         d_in = req.divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            r_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = shifted[63:0];
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = !busy_ff && !req.start;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

// File: rtl/per_address_token_bucket_limiter.sv
// Top level of the per-address token bucket limiter: hash, probe, refill sequencer.
// Depends on patbl_pkg and patbl_div.
//
//  channel | direction | ports
//  req     | in        | req_valid/req_stall, addr_family, addr_high, addr_low, now_ms
//  rsp     | out       | rsp_valid/rsp_stall, allowed, failed_open, evicted_entry
//  csr     | in        | APB write/read, 4 registers at byte addresses 0,4,8,12
//
// A looked-up item passes through these steps after it is taken: 5 (IPv4) or 9 (IPv6) hash
// rounds (each a 64x64 multiply done in two 64x32 halves), the modulo on the shared
// divider, a read, wait and check per probe (up to 32, one memory read port), a further
// read and wait on eviction, refill multiply, refill division, then update and output.
// Fail-open items skip the lookup and go from idle straight to output. Each item also
// passes through idle; no item is taken while a result waits unless it leaves at that edge.
// After reset the table is swept clear, one slot a cycle, before items are taken. The result
// register holds while rsp_stall is high.
`timescale 1ns / 1ps
module per_address_token_bucket_limiter
   import patbl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_addr_family,
   input  logic [63:0] req_addr_high,
   input  logic [63:0] req_addr_low,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_allowed,
   output logic        rsp_failed_open,
   output logic        rsp_evicted_entry,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   // configuration registers
   logic [31:0] refill_ff, cap_ff;
   logic [21:0] period_ff;
   logic [10:0] slots_ff;
   logic        csr_wr;
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         refill_ff <= 32'd1000;
         period_ff <= 22'd1000;
         cap_ff <= 32'd1000;
         slots_ff <= 11'd1024;
      end else if (csr_wr && paddr[1:0] == 2'b00) begin
         unique case ({1'b0, paddr[3:2]})
            RegRefill:   refill_ff <= pwdata;
            RegPeriod:   period_ff <= pwdata[21:0];
            RegCapacity: cap_ff <= pwdata;
            RegSlots:    slots_ff <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         unique case ({1'b0, paddr[3:2]})
            RegRefill:   prdata = refill_ff;
            RegPeriod:   prdata = {10'd0, period_ff};
            RegCapacity: prdata = cap_ff;
            RegSlots:    prdata = {21'd0, slots_ff};
            default:     prdata = '0;
         endcase
      end
   end

   // effective slot count and period
   logic [10:0] nslots;
   logic [21:0] period_eff;
   assign nslots = (slots_ff > 11'(TableSlots)) ? 11'(TableSlots) : slots_ff;
   assign period_eff = (period_ff == '0) ? 22'd1 : period_ff;

   // table memories: key and bucket, one port each
   logic [63:0] key_mem [TableSlots];
   logic [63:0] bkt_mem [TableSlots];
   logic [SlotIdxW-1:0] mem_addr;
   logic        mem_we;
   logic [63:0] wr_key, wr_bkt, rd_key_ff, rd_bkt_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_addr] <= wr_key;
         bkt_mem[mem_addr] <= wr_bkt;
      end
      rd_key_ff <= key_mem[mem_addr];
      rd_bkt_ff <= bkt_mem[mem_addr];
   end

   // shared divider
   div_req_type div_req;
   logic        div_done;
   logic [63:0] div_q, div_r;
   patbl_div u_div (
      .clock(clock), .reset(reset), .req(div_req),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   // datapath registers
   state_type   state_ff, state_in;
   logic [63:0] hash_ff, hash_in, ppl_ff, ppl_in;
   logic [63:0] word_ff, word_in;
   logic [3:0]  nbyte_ff, nbyte_in;
   logic [31:0] now_ff, now_in;
   logic [10:0] pos_ff, pos_in;
   logic [ProbeW-1:0] probe_ff, probe_in;
   logic [SlotIdxW-1:0] oldest_ff, oldest_in, hit_ff, hit_in;
   logic [31:0] best_ff, best_in;
   logic        evict_ff, evict_in, claim_ff, claim_in;
   logic [63:0] prod_ff, prod_in;
   logic [SlotIdxW:0] clr_ff, clr_in;
   logic        ovalid_ff, ovalid_in, oallow_ff, oallow_in, ofo_ff, ofo_in;
   logic        oev_ff, oev_in;
   logic [63:0] key_fix;
   logic [31:0] age, o_ts, o_tok;
   logic [64:0] newtok;
   logic [31:0] tok;
   logic        allow;
   logic [7:0]  cur_byte;
   logic [11:0] pos_nx;
   logic        mapped;
   logic        out_free;

   assign key_fix = (hash_ff == '0) ? 64'd1 : hash_ff;
   assign age = now_ff - rd_bkt_ff[63:32];
   assign cur_byte = word_ff[63:56];
   assign pos_nx = {1'b0, pos_ff} + 12'd1;
   assign o_ts = evict_ff ? 32'd0 : rd_bkt_ff[63:32];
   assign o_tok = evict_ff ? 32'd0 : rd_bkt_ff[31:0];
   assign newtok = {33'd0, o_tok} + {1'b0, div_q};
   assign tok = (newtok > {33'd0, cap_ff}) ? cap_ff : newtok[31:0];
   assign allow = tok >= 32'(TokenScale);
   assign mapped = (req_addr_high == '0) && (req_addr_low[63:32] == 32'h0000ffff);
   // result register is empty or its item leaves at this edge
   assign out_free = !ovalid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:
            if (clr_ff == 11'(TableSlots - 1)) state_in = ST_IDLE;
         ST_IDLE:
            if (req_valid && out_free) begin
               if (req_addr_family[1] || nslots == '0) state_in = ST_OUT;
               else state_in = ST_HASH_MUL;
            end
         ST_HASH_MUL: state_in = ST_HASH_ACC;
         ST_HASH_ACC:
            if (nbyte_ff == '0) state_in = ST_MOD_START;
            else state_in = ST_HASH_MUL;
         ST_MOD_START: state_in = ST_MOD_WAIT;
         ST_MOD_WAIT:  if (div_done) state_in = ST_PROBE_RD;
         ST_PROBE_RD:  state_in = ST_PROBE_WAIT;
         ST_PROBE_WAIT: state_in = ST_PROBE_CHK;
         ST_PROBE_CHK:
            if (rd_key_ff == '0 || rd_key_ff == key_fix) state_in = ST_MUL_LO;
            else if (probe_ff == ProbeW'(ProbeWindow - 1)) state_in = ST_HIT_RD;
            else state_in = ST_PROBE_RD;
         ST_HIT_RD:   state_in = ST_HIT_WAIT;
         ST_HIT_WAIT: state_in = ST_MUL_LO;
         ST_MUL_LO:   state_in = ST_MUL_HI;
         ST_MUL_HI:   state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_OUT;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      hash_in = hash_ff; ppl_in = ppl_ff; word_in = word_ff; nbyte_in = nbyte_ff;
      now_in = now_ff; pos_in = pos_ff; probe_in = probe_ff;
      oldest_in = oldest_ff; hit_in = hit_ff; best_in = best_ff; evict_in = evict_ff;
      claim_in = claim_ff; prod_in = prod_ff; clr_in = clr_ff;
      ovalid_in = ovalid_ff; oallow_in = oallow_ff; ofo_in = ofo_ff; oev_in = oev_ff;
      mem_addr = pos_ff[SlotIdxW-1:0]; mem_we = 1'b0; wr_key = '0; wr_bkt = '0;
      div_req = '{start: 1'b0, dividend: '0, divisor: '0};
      req_stall = 1'b1;
      if (ovalid_ff && !rsp_stall) ovalid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_addr = clr_ff[SlotIdxW-1:0];
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_stall = !out_free;
            now_in = req_now_ms;
            hash_in = HashBasis ^ {56'd0, (req_addr_family == 2'd1 && !mapped) ?
                                  TagIpv6 : TagIpv4};
            if (req_addr_family == 2'd1 && !mapped) begin
               word_in = req_addr_high;
               nbyte_in = 4'd8;
            end else begin
               word_in = {req_addr_low[31:0], 32'd0};
               nbyte_in = 4'd4;
            end
            probe_in = '0; best_in = '0; oldest_in = '0; evict_in = 1'b0;
         end
         // hash * mult in two 64x32 halves: low half then high half
         ST_HASH_MUL: ppl_in = hash_ff * {32'd0, HashMult[31:0]};
         ST_HASH_ACC: begin
            hash_in = ppl_ff + {hash_ff[31:0] * HashMult[63:32], 32'd0};
            if (nbyte_ff != '0) begin
               hash_in = (ppl_ff + {hash_ff[31:0] * HashMult[63:32], 32'd0}) ^
                         {56'd0, cur_byte};
               word_in = {word_ff[55:0], 8'd0};
               nbyte_in = nbyte_ff - 4'd1;
            end
         end
         ST_MOD_START: div_req = '{start: 1'b1, dividend: key_fix,
                                   divisor: {53'd0, nslots}};
         ST_MOD_WAIT: if (div_done) pos_in = div_r[10:0];
         ST_PROBE_RD: ;
         ST_PROBE_WAIT: ;
         ST_PROBE_CHK: begin
            hit_in = pos_ff[SlotIdxW-1:0];
            if (rd_key_ff == '0 || rd_key_ff == key_fix) begin
               claim_in = 1'b1;
            end else begin
               if (age >= best_ff) begin
                  best_in = age;
                  oldest_in = pos_ff[SlotIdxW-1:0];
               end
               pos_in = (pos_nx >= {1'b0, nslots}) ? 11'(pos_nx - {1'b0, nslots})
                                                   : pos_nx[10:0];
               probe_in = probe_ff + 1'b1;
               if (probe_ff == ProbeW'(ProbeWindow - 1)) begin
                  evict_in = 1'b1;
                  hit_in = (age >= best_ff) ? pos_ff[SlotIdxW-1:0] : oldest_ff;
               end
            end
         end
         ST_HIT_RD: mem_addr = hit_ff;
         ST_HIT_WAIT: mem_addr = hit_ff;
         ST_MUL_LO: prod_in = {32'd0, now_ff - o_ts} * {48'd0, refill_ff[15:0]};
         ST_MUL_HI: prod_in = prod_ff +
                              ({32'd0, now_ff - o_ts} * {48'd0, refill_ff[31:16]} << 16);
         ST_DIV_START: div_req = '{start: 1'b1, dividend: prod_ff,
                                   divisor: {42'd0, period_eff}};
         ST_DIV_WAIT: ;
         ST_UPDATE: begin
            mem_addr = hit_ff;
            mem_we = 1'b1;
            wr_key = key_fix;
            wr_bkt = {(div_q != '0) ? now_ff : o_ts, allow ? tok - 32'(TokenScale) : tok};
            oallow_in = allow; ofo_in = 1'b0; oev_in = evict_ff;
         end
         ST_OUT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               if (evict_ff == 1'b0 && claim_ff == 1'b0 && probe_ff == '0 &&
                   hash_ff == HashBasis) begin
                  oallow_in = oallow_ff;
               end
            end
         end
         default: ;
      endcase
   end

   // fail-open results bypass lookup
   logic fo_ff, fo_in;
   assign fo_in = (state_ff == ST_IDLE && req_valid && out_free) ?
                  (req_addr_family[1] || nslots == '0) : fo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         ovalid_ff <= 1'b0;
         fo_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         ovalid_ff <= ovalid_in;
         fo_ff <= fo_in;
      end
      hash_ff <= hash_in; ppl_ff <= ppl_in; word_ff <= word_in; nbyte_ff <= nbyte_in;
      now_ff <= now_in; pos_ff <= pos_in; probe_ff <= probe_in;
      oldest_ff <= oldest_in; hit_ff <= hit_in; best_ff <= best_in; evict_ff <= evict_in;
      claim_ff <= claim_in; prod_ff <= prod_in;
      oallow_ff <= (state_ff == ST_OUT && fo_ff) ? 1'b1 : oallow_in;
      ofo_ff <= (state_ff == ST_OUT && fo_ff) ? 1'b1 : ofo_in;
      oev_ff <= (state_ff == ST_OUT && fo_ff) ? 1'b0 : oev_in;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_allowed = oallow_ff;
   assign rsp_failed_open = ofo_ff;
   assign rsp_evicted_entry = oev_ff;
endmodule
